// ----- rtl/software_timer_scheduler_unit_macros.svh -----
// Assertion macros shared by the checker
`ifndef SOFTWARE_TIMER_SCHEDULER_UNIT_MACROS_SVH
`define SOFTWARE_TIMER_SCHEDULER_UNIT_MACROS_SVH

// Check a property out of reset
`define STS_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property that also holds right after reset
`define STS_CHECK_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/sts_pkg.sv -----
package sts_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int ID_W          = 31;
   localparam int TIME_W        = 64;
   localparam int FREQ_W        = 32;
   localparam int PROD_W        = 64;
   localparam int REM_W         = 10;
   localparam int DIGIT_W       = 16;
   localparam int CUR_W         = REM_W + DIGIT_W;
   localparam int RECIP_W       = 27;
   localparam int RECIP_SH      = 36;
   localparam int BIT_W         = 2;
   localparam logic [FREQ_W-1:0]  FREQ_RESET = 32'd1000;
   localparam logic [REM_W:0]     MS_PER_S   = 11'd1000;
   // ceil(2^36 / 1000): exact quotient for every dividend below 2^26
   localparam logic [RECIP_W-1:0] RECIP_1000 = 27'd68719477;

   typedef enum logic [2:0] {
      K_TIMEOUT  = 3'd0,
      K_INTERVAL = 3'd1,
      K_CANCEL   = 3'd2,
      K_PROCESS  = 3'd3,
      K_CLEAR    = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      R_ASSIGNED = 3'd0,
      R_FIRED    = 3'd1,
      R_DONE     = 3'd2,
      R_FULL     = 3'd3,
      R_ACK      = 3'd4
   } rsp_kind_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] deadline;
      logic [ID_W-1:0]   period;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

endpackage

// ----- rtl/software_timer_scheduler_unit.sv -----
// Timer slot table for one-shot and periodic timers.
// Request channel: a beat is taken at a clock edge with start high and busy low;
// req_kind selects set timeout, set interval, cancel, process or clear all.
// Result channel: each beat shows on the rsp_ ports for one cycle, marked by
// rsp_strobe, and rsp_last marks the final beat of a request. The receiver
// cannot stall, so no result is ever held back.
// csr_write_enable writes counter_frequency (ticks per second); write it idle.
// Sequence of each request kind, from the accepting edge:
//   clear all, unused kinds and a set into a full table: busy stays low and
//   the beat shows in the next cycle.
//   set: busy through one multiply, four radix-65536 reciprocal steps of the
//   divide by 1000 and one write, with the beat in the first idle cycle.
//   cancel: busy for one pass over the slot RAM.
//   process: a pre-scan pass, then a select pass and a pick per due slot
//   and once more to finish; an interval rearm adds a multiply, divide, write.
// One request is worked at a time. Deadline, id and period sit in one RAM with
// a registered read; used and cancelled flags are flip-flops. Reset clears the
// table, sets next id to 1 and counter_frequency to 1000, with no clearing pass.
module software_timer_scheduler_unit import sts_pkg::*; #(
   parameter int TIMER_SLOTS = SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_kind,
   input  logic [ID_W-1:0]   req_delay_ms,
   input  logic [ID_W-1:0]   req_target_id,
   input  logic [TIME_W-1:0] req_now,
   output logic              rsp_strobe,
   output logic [2:0]        rsp_result_kind,
   output logic [ID_W-1:0]   rsp_task_id,
   output logic              rsp_pending,
   output logic              rsp_last,
   input  logic              csr_write_enable,
   input  logic [FREQ_W-1:0] csr_write_data
);

   localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(TIMER_SLOTS + 1);
   localparam logic [CW-1:0] SCAN_END = CW'(TIMER_SLOTS);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_DIV, S_SET_WR, S_CSCAN, S_PSCAN, S_SEL, S_PICK, S_REARM
   } state_type;

   state_type         state_ff, state_in;
   req_kind_type      kind_ff, kind_in;
   logic [ID_W-1:0]   delay_ff, delay_in;
   logic [ID_W-1:0]   target_ff, target_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [TIMER_SLOTS-1:0] used_ff, used_in, canc_ff, canc_in, due_ff, due_in;
   logic [ID_W-1:0]   next_id_ff, next_id_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic              pend_ff, pend_in;
   logic              best_vld_ff, best_vld_in;
   logic [AW-1:0]     best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_dl_ff, best_dl_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;
   logic [ID_W-1:0]   best_per_ff, best_per_in;
   logic [ID_W-1:0]   ms_ff, ms_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_kind_type      rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_pend_ff, rsp_pend_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   slot_entry_type    ram_wdata, ram_rdata;
   logic [ENTRY_W-1:0] ram_rdata_raw;

   logic              has_free;
   logic [AW-1:0]     free_idx;
   logic [CUR_W-1:0]  div_cur;
   logic [CUR_W+RECIP_W-1:0] div_mul;
   logic [DIGIT_W-1:0] div_q;
   logic [REM_W-1:0]  div_rem;
   logic [TIME_W-1:0] ticks_dl;
   logic              rd_due, rd_better;
   logic [ID_W-1:0]   id_inc;

   sts_ram #(.WIDTH(ENTRY_W), .DEPTH(TIMER_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );
   assign ram_rdata = slot_entry_type'(ram_rdata_raw);

   // Find the lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = AW'(i);
         end
      end
   end
   assign has_free = ~&used_ff;

   // One radix-65536 digit of the divide by 1000 by reciprocal multiplication
   assign div_cur  = {rem_ff, prod_ff[PROD_W-1 -: DIGIT_W]};
   assign div_mul  = (CUR_W+RECIP_W)'(div_cur) * (CUR_W+RECIP_W)'(RECIP_1000);
   assign div_q    = div_mul[RECIP_SH +: DIGIT_W];
   assign div_rem  = div_cur[REM_W-1:0] - REM_W'(div_q[REM_W-1:0] * MS_PER_S[REM_W-1:0]);
   assign ticks_dl = now_ff + prod_ff;
   assign id_inc   = next_id_ff + 1'b1;

   assign rd_due    = rd_vld_ff && due_ff[rd_idx_ff];
   assign rd_better = !best_vld_ff || (ram_rdata.deadline < best_dl_ff) ||
                      ((ram_rdata.deadline == best_dl_ff) && (ram_rdata.id < best_id_ff));

   assign ram_raddr = cnt_ff[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      delay_in      = delay_ff;
      target_in     = target_ff;
      now_in        = now_ff;
      freq_in       = freq_ff;
      used_in       = used_ff;
      canc_in       = canc_ff;
      due_in        = due_ff;
      next_id_in    = next_id_ff;
      slot_in       = slot_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = cnt_ff[AW-1:0];
      pend_in       = pend_ff;
      best_vld_in   = best_vld_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_id_in    = best_id_ff;
      best_per_in   = best_per_ff;
      ms_in         = ms_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      bit_in        = bit_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = '0;
      rsp_pend_in   = rsp_pend_ff;
      rsp_last_in   = 1'b1;
      ram_we        = 1'b0;
      ram_waddr     = slot_ff;
      ram_wdata     = '{id: next_id_ff, deadline: ticks_dl,
                        period: (kind_ff == K_INTERVAL) ? delay_ff : '0};

      if (csr_write_enable) begin
         freq_in = csr_write_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in   = req_kind_type'(req_kind);
               delay_in  = req_delay_ms;
               target_in = req_target_id;
               now_in    = req_now;
               ms_in     = req_delay_ms;
               slot_in   = free_idx;
               cnt_in    = '0;
               case (req_kind) inside
                  K_TIMEOUT, K_INTERVAL: begin
                     if (has_free) begin
                        state_in = S_MUL;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_kind_in   = R_FULL;
                        rsp_pend_in   = 1'b1;
                     end
                  end
                  K_CANCEL:  state_in = S_CSCAN;
                  K_PROCESS: begin
                     state_in = S_PSCAN;
                     due_in   = '0;
                     pend_in  = 1'b0;
                  end
                  K_CLEAR: begin
                     used_in       = '0;
                     canc_in       = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = R_ACK;
                     rsp_pend_in   = 1'b0;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = R_ACK;
                     rsp_pend_in   = |used_ff;
                  end
               endcase
            end
         end
         S_MUL: begin
            // Multiply milliseconds by ticks per second
            prod_in  = PROD_W'(ms_ff) * PROD_W'(freq_ff);
            rem_in   = '0;
            bit_in   = BIT_W'(PROD_W / DIGIT_W - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            // Shift in one quotient digit, keep the remainder
            prod_in = {prod_ff[PROD_W-DIGIT_W-1:0], div_q};
            rem_in  = div_rem;
            bit_in  = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = (kind_ff == K_PROCESS) ? S_REARM : S_SET_WR;
            end
         end
         S_SET_WR: begin
            // Store the new timer and return its id
            ram_we           = 1'b1;
            used_in[slot_ff] = 1'b1;
            canc_in[slot_ff] = 1'b0;
            rsp_strobe_in    = 1'b1;
            rsp_kind_in      = R_ASSIGNED;
            rsp_id_in        = next_id_ff;
            rsp_pend_in      = 1'b1;
            next_id_in       = (id_inc == '0) ? ID_W'(1) : id_inc;
            state_in         = S_IDLE;
         end
         S_CSCAN: begin
            // Mark every used slot with the target id
            if (cnt_ff != SCAN_END) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            if (rd_vld_ff && used_ff[rd_idx_ff] && ram_rdata.id == target_ff) begin
               canc_in[rd_idx_ff] = 1'b1;
            end
            if (cnt_ff == SCAN_END && !rd_vld_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = R_ACK;
               rsp_pend_in   = |used_ff;
               state_in      = S_IDLE;
            end
         end
         S_PSCAN: begin
            // Collect due slots and what stays occupied afterward
            if (cnt_ff != SCAN_END) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            if (rd_vld_ff && used_ff[rd_idx_ff]) begin
               if (ram_rdata.deadline <= now_ff) begin
                  due_in[rd_idx_ff] = 1'b1;
                  if (!canc_ff[rd_idx_ff] && ram_rdata.period != '0) begin
                     pend_in = 1'b1;
                  end
               end else begin
                  pend_in = 1'b1;
               end
            end
            if (cnt_ff == SCAN_END && !rd_vld_ff) begin
               cnt_in      = '0;
               best_vld_in = 1'b0;
               state_in    = S_SEL;
            end
         end
         S_SEL: begin
            // Find the earliest due slot, ties by id then index
            if (cnt_ff != SCAN_END) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            if (rd_due && rd_better) begin
               best_vld_in = 1'b1;
               best_idx_in = rd_idx_ff;
               best_dl_in  = ram_rdata.deadline;
               best_id_in  = ram_rdata.id;
               best_per_in = ram_rdata.period;
            end
            if (cnt_ff == SCAN_END && !rd_vld_ff) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            cnt_in      = '0;
            best_vld_in = 1'b0;
            state_in    = S_SEL;
            if (!best_vld_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = R_DONE;
               rsp_pend_in   = pend_ff;
               state_in      = S_IDLE;
            end else begin
               due_in[best_idx_ff] = 1'b0;
               slot_in             = best_idx_ff;
               if (canc_ff[best_idx_ff]) begin
                  // Drop a cancelled slot silently
                  used_in[best_idx_ff] = 1'b0;
                  canc_in[best_idx_ff] = 1'b0;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_kind_in   = R_FIRED;
                  rsp_id_in     = best_id_ff;
                  rsp_pend_in   = pend_ff;
                  rsp_last_in   = 1'b0;
                  if (best_per_ff != '0) begin
                     ms_in    = best_per_ff;
                     state_in = S_MUL;
                  end else begin
                     used_in[best_idx_ff] = 1'b0;
                  end
               end
            end
         end
         S_REARM: begin
            // Write the new deadline of an interval slot
            ram_we      = 1'b1;
            ram_wdata   = '{id: best_id_ff, deadline: ticks_dl, period: best_per_ff};
            cnt_in      = '0;
            best_vld_in = 1'b0;
            state_in    = S_SEL;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         freq_ff       <= FREQ_RESET;
         used_ff       <= '0;
         canc_ff       <= '0;
         next_id_ff    <= ID_W'(1);
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         freq_ff       <= freq_in;
         used_ff       <= used_in;
         canc_ff       <= canc_in;
         next_id_ff    <= next_id_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      kind_ff     <= kind_in;
      delay_ff    <= delay_in;
      target_ff   <= target_in;
      now_ff      <= now_in;
      due_ff      <= due_in;
      slot_ff     <= slot_in;
      cnt_ff      <= cnt_in;
      rd_idx_ff   <= rd_idx_in;
      pend_ff     <= pend_in;
      best_vld_ff <= best_vld_in;
      best_idx_ff <= best_idx_in;
      best_dl_ff  <= best_dl_in;
      best_id_ff  <= best_id_in;
      best_per_ff <= best_per_in;
      ms_ff       <= ms_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_pend_ff <= rsp_pend_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_task_id     = rsp_id_ff;
   assign rsp_pending     = rsp_pend_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- rtl/sts_ram.sv -----
module sts_ram import sts_pkg::*; #(
   parameter int WIDTH = ENTRY_W,
   parameter int DEPTH = SLOTS_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- rtl/sts_checker.sv -----
`include "software_timer_scheduler_unit_macros.svh"

module sts_checker import sts_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_strobe,
   input logic [2:0]        rsp_result_kind,
   input logic [ID_W-1:0]   rsp_task_id,
   input logic              rsp_last
);

   // No result beat right after reset
   `STS_CHECK_RST(a_no_beat_after_reset, $past(reset) |-> !rsp_strobe, "beat after reset")
   // Only fire beats leave more beats to come
   `STS_CHECK(a_mid_is_fire, (rsp_strobe && !rsp_last) |-> (rsp_result_kind == R_FIRED), "mid beat not a fire")
   // A fire or an assignment carries a real id
   `STS_CHECK(a_id_nonzero, (rsp_strobe && (rsp_result_kind == R_FIRED || rsp_result_kind == R_ASSIGNED)) |-> (rsp_task_id != '0), "zero id")
   // More beats pending keeps the block busy
   `STS_CHECK(a_busy_mid, (rsp_strobe && !rsp_last) |-> busy, "idle with beats pending")
   // The last beat of a request shows while the block is idle
   `STS_CHECK(a_last_idle, (rsp_strobe && rsp_last) |-> !busy, "last beat while busy")

endmodule

bind software_timer_scheduler_unit sts_checker u_sts_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_result_kind (rsp_result_kind),
   .rsp_task_id     (rsp_task_id),
   .rsp_last        (rsp_last)
);

// ----- bench/tb_software_timer_scheduler_unit.sv -----
module tb_software_timer_scheduler_unit import sts_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = SLOTS_DEFAULT;
   localparam int IDLE_LIMIT  = 20000;
   localparam int END_CYCLES  = 200;
   localparam logic [2:0] K_SPARE_FIRST = 3'd5;
   localparam logic [2:0] K_SPARE_LAST  = 3'd7;
   localparam logic [ID_W-1:0] ID_MAX   = {ID_W{1'b1}};

   typedef struct {
      rsp_kind_type    kind;
      logic [ID_W-1:0] id;
      logic            pending;
      logic            last;
   } rsp_beat_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [2:0]        req_kind;
   logic [ID_W-1:0]   req_delay_ms;
   logic [ID_W-1:0]   req_target_id;
   logic [TIME_W-1:0] req_now;
   logic              rsp_strobe;
   logic [2:0]        rsp_result_kind;
   logic [ID_W-1:0]   rsp_task_id;
   logic              rsp_pending;
   logic              rsp_last;
   logic              csr_write_enable;
   logic [FREQ_W-1:0] csr_write_data;

   // Shadow timer table
   logic              tbl_used      [SLOTS];
   logic              tbl_cancelled [SLOTS];
   logic [ID_W-1:0]   tbl_id        [SLOTS];
   logic [TIME_W-1:0] tbl_deadline  [SLOTS];
   logic [ID_W-1:0]   tbl_period    [SLOTS];
   logic [ID_W-1:0]   tbl_next_id;
   logic [FREQ_W-1:0] tbl_freq;

   rsp_beat_type      expected_beats[$];
   int                mismatches = 0;
   int                idle_cycles = 0;
   logic [TIME_W-1:0] sim_now = '0;

   software_timer_scheduler_unit #(.TIMER_SLOTS(SLOTS)) dut (.*);

   always #1 clock = ~clock;

   function automatic logic [TIME_W-1:0] ms_to_ticks(input logic [ID_W-1:0] ms);
      return (64'(ms) * 64'(tbl_freq)) / 64'd1000;
   endfunction

   // Compute the result beats of one accepted request and update the table
   task automatic timer_table_step(input logic [2:0] kind, input logic [ID_W-1:0] delay,
                                   input logic [ID_W-1:0] target,
                                   input logic [TIME_W-1:0] now);
      rsp_kind_type    kinds[$];
      logic [ID_W-1:0] ids[$];
      logic            due[SLOTS];
      int              free_i;
      int              best;
      logic            any;
      rsp_beat_type    b;
      free_i = -1;
      if (kind == K_TIMEOUT || kind == K_INTERVAL) begin
         for (int i = SLOTS - 1; i >= 0; i--)
            if (!tbl_used[i]) free_i = i;
         if (free_i < 0) begin
            kinds = {kinds, R_FULL}; ids = {ids, ID_W'(0)};
         end else begin
            tbl_used[free_i]      = 1'b1;
            tbl_cancelled[free_i] = 1'b0;
            tbl_id[free_i]        = tbl_next_id;
            tbl_deadline[free_i]  = now + ms_to_ticks(delay);
            tbl_period[free_i]    = (kind == K_INTERVAL) ? delay : '0;
            kinds = {kinds, R_ASSIGNED}; ids = {ids, tbl_next_id};
            tbl_next_id = tbl_next_id + 1'b1;
            if (tbl_next_id == '0) tbl_next_id = ID_W'(1);
         end
      end else if (kind == K_CANCEL) begin
         for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_id[i] == target) tbl_cancelled[i] = 1'b1;
         kinds = {kinds, R_ACK}; ids = {ids, ID_W'(0)};
      end else if (kind == K_PROCESS) begin
         for (int i = 0; i < SLOTS; i++) due[i] = tbl_used[i] && tbl_deadline[i] <= now;
         forever begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
               if (due[i] && (best < 0 || tbl_deadline[i] < tbl_deadline[best] ||
                   (tbl_deadline[i] == tbl_deadline[best] && tbl_id[i] < tbl_id[best])))
                  best = i;
            if (best < 0) break;
            due[best] = 1'b0;
            if (tbl_cancelled[best]) begin
               // drop a due cancelled slot without a beat
               tbl_used[best] = 1'b0;
               tbl_cancelled[best] = 1'b0;
            end else begin
               kinds = {kinds, R_FIRED}; ids = {ids, tbl_id[best]};
               if (tbl_period[best] != '0) tbl_deadline[best] = now + ms_to_ticks(tbl_period[best]);
               else tbl_used[best] = 1'b0;
            end
         end
         kinds = {kinds, R_DONE}; ids = {ids, ID_W'(0)};
      end else if (kind == K_CLEAR) begin
         for (int i = 0; i < SLOTS; i++) begin
            tbl_used[i] = 1'b0;
            tbl_cancelled[i] = 1'b0;
         end
         kinds = {kinds, R_ACK}; ids = {ids, ID_W'(0)};
      end else begin
         kinds = {kinds, R_ACK}; ids = {ids, ID_W'(0)};
      end
      any = 1'b0;
      for (int i = 0; i < SLOTS; i++) any |= tbl_used[i];
      foreach (kinds[k]) begin
         b.kind = kinds[k]; b.id = ids[k]; b.pending = any;
         b.last = (k == kinds.size() - 1);
         expected_beats = {expected_beats, b};
      end
   endtask

   task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
      mismatches++;
   endtask

   // Send one request beat after a random gap
   task automatic send_request(input logic [2:0] kind, input logic [ID_W-1:0] delay,
                               input logic [ID_W-1:0] target, input logic [TIME_W-1:0] now);
      int gap;
      gap = $urandom_range(0, 14);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_kind      <= kind;
      req_delay_ms  <= delay;
      req_target_id <= target;
      req_now       <= now;
      do @(posedge clock); while (busy);
      timer_table_step(kind, delay, target, now);
   endtask

   // Hold off until every expected beat has come and the block is idle
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (expected_beats.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_frequency(input logic [FREQ_W-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tbl_freq = value;
   endtask

   task automatic test_basic_timers();
      send_request(K_TIMEOUT, '0, '0, '0);
      send_request(K_INTERVAL, 31'd5, '0, '0);
      send_request(K_INTERVAL, '0, '0, '0);
      send_request(K_PROCESS, '0, '0, 64'd10);
      for (logic [3:0] k = {1'b0, K_SPARE_FIRST}; k <= {1'b0, K_SPARE_LAST}; k++)
         send_request(k[2:0], ID_MAX, ID_MAX, '1);
      send_request(K_CANCEL, '0, ID_MAX, '0);
      send_request(K_CANCEL, '0, 31'd2, '0);
      send_request(K_PROCESS, '0, '0, 64'd100);
      // deadline wraps past the top of the counter
      send_request(K_TIMEOUT, ID_MAX, '0, '1);
      send_request(K_PROCESS, '0, '0, '1);
      send_request(K_CLEAR, '0, '0, '0);
   endtask

   task automatic test_table_full();
      for (int i = 0; i <= SLOTS; i++)
         send_request(i[0] ? K_INTERVAL : K_TIMEOUT, 31'(i), '0, 64'd50);
      send_request(K_PROCESS, '0, '0, 64'd60);
      send_request(K_CLEAR, '0, '0, '0);
   endtask

   task automatic test_frequency();
      logic [FREQ_W-1:0] freqs[4] = '{32'd1, '1, 32'd0, FREQ_RESET};
      foreach (freqs[f]) begin
         write_frequency(freqs[f]);
         send_request(K_TIMEOUT, ID_MAX, '0, 64'd1000);
         send_request(K_INTERVAL, 31'd7, '0, 64'd1000);
         send_request(K_PROCESS, '0, '0, 64'd1007);
         send_request(K_CLEAR, '0, '0, '0);
      end
   endtask

   task automatic test_random_traffic();
      int r;
      logic [ID_W-1:0] delay;
      logic [ID_W-1:0] target;
      for (int n = 0; n < 170; n++) begin
         if (n == 100) drain();
         r = $urandom_range(0, 99);
         if (r < 40 || r >= 95) begin
            case ($urandom_range(0, 6))
               0: delay = '0;
               1: delay = ID_W'($urandom);
               default: delay = ID_W'($urandom_range(0, 20));
            endcase
            send_request($urandom_range(0, 1) ? K_INTERVAL : K_TIMEOUT, delay, '0,
                         r >= 95 ? {$urandom, $urandom} : sim_now);
         end else if (r < 55) begin
            target = $urandom_range(0, 9) == 0 ? ID_W'($urandom)
                   : tbl_next_id - ID_W'($urandom_range(1, 6));
            send_request(K_CANCEL, ID_W'($urandom), target, {$urandom, $urandom});
         end else if (r < 85) begin
            sim_now = $urandom_range(0, 19) == 0 ? {$urandom, $urandom}
                    : sim_now + 64'($urandom_range(0, 30));
            send_request(K_PROCESS, ID_W'($urandom), ID_W'($urandom), sim_now);
         end else if (r < 90) begin
            send_request(K_CLEAR, ID_W'($urandom), ID_W'($urandom), {$urandom, $urandom});
         end else begin
            send_request(3'($urandom_range(K_SPARE_FIRST, K_SPARE_LAST)), ID_W'($urandom),
                         ID_W'($urandom), {$urandom, $urandom});
         end
      end
   endtask

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_strobe) begin
         if (expected_beats.size() == 0) begin
            report("unexpected beat", 64'(rsp_result_kind), '0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_result_kind !== want.kind)
               report("result_kind", 64'(rsp_result_kind), 64'(want.kind));
            if (rsp_task_id !== want.id) report("task_id", 64'(rsp_task_id), 64'(want.id));
            if (rsp_pending !== want.pending)
               report("pending", 64'(rsp_pending), 64'(want.pending));
            if (rsp_last !== want.last) report("last", 64'(rsp_last), 64'(want.last));
         end
      end
   end

   // Watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_kind         <= K_TIMEOUT;
      req_delay_ms     <= '0;
      req_target_id    <= '0;
      req_now          <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_used[i] = 1'b0;
         tbl_cancelled[i] = 1'b0;
      end
      tbl_next_id = ID_W'(1);
      tbl_freq    = FREQ_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_timers();
      test_table_full();
      test_frequency();
      test_random_traffic();
      start <= 1'b0;
      do @(posedge clock); while (expected_beats.size() != 0);
      repeat (END_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- software_timer_scheduler_unit.f -----
+incdir+rtl
rtl/sts_pkg.sv
rtl/sts_ram.sv
rtl/software_timer_scheduler_unit.sv
rtl/sts_checker.sv
bench/tb_software_timer_scheduler_unit.sv
